>>> rtl/btnode_pkg.sv
// ============================================================================
// btnode_pkg
// Shared types and constants for the B+ tree internal node engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package btnode_pkg;

    localparam int KEY_SLOTS_DEF  = 32;
    localparam int KEY_BITS_DEF   = 16;
    localparam int CHILD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_SPLIT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SPLIT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_EXEC = 2'd2,
        S_EMIT = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/btnode_cell.sv
// ============================================================================
// btnode_cell
// One slot of the node: a key and the child to its right, with a compare
// against the search key and moves to and from the neighboring slots.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module btnode_cell #(
    parameter int KEY_BITS   = btnode_pkg::KEY_BITS_DEF,
    parameter int CHILD_BITS = btnode_pkg::CHILD_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire btnode_pkg::t_cell_ctrl i_ctrl,
    input  wire  [KEY_BITS-1:0]        i_cmp_key,
    input  wire  [KEY_BITS-1:0]        i_new_key,
    input  wire  [CHILD_BITS-1:0]      i_new_child,
    input  wire  [KEY_BITS-1:0]        i_left_key,
    input  wire  [CHILD_BITS-1:0]      i_left_child,
    input  wire  [KEY_BITS-1:0]        i_right_key,
    input  wire  [CHILD_BITS-1:0]      i_right_child,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [CHILD_BITS-1:0]      o_child,
    output logic                       o_gt
);

    logic [KEY_BITS-1:0]   r_key;
    logic [CHILD_BITS-1:0] r_child;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key   <= i_new_key;
            r_child <= i_new_child;
        end else if (i_ctrl.from_left) begin
            r_key   <= i_left_key;
            r_child <= i_left_child;
        end else if (i_ctrl.from_right) begin
            r_key   <= i_right_key;
            r_child <= i_right_child;
        end
    end

    assign o_key   = r_key;
    assign o_child = r_child;
    assign o_gt    = (r_key > i_cmp_key);

endmodule

`default_nettype wire

>>> rtl/btree_internal_node_engine.sv
// ============================================================================
// btree_internal_node_engine
// One B+ tree internal node kept in a row of key/child cells, with init,
// lookup, insert and split-insert commands.
// ============================================================================
// Init, lookup and insert: a compare state, then a cell-update state, then
// a registered result strobe. Split-insert: L - L/2 results (L = keys + 1)
// on consecutive cycles, registered from the emit state that follows the
// compare and update states. No new command is taken while busy; busy
// drops during the last strobe. Synchronous reset clears the key count
// and the control; slot contents stay undefined. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module btree_internal_node_engine #(
    parameter int KEY_SLOTS  = btnode_pkg::KEY_SLOTS_DEF,
    parameter int KEY_BITS   = btnode_pkg::KEY_BITS_DEF,
    parameter int CHILD_BITS = btnode_pkg::CHILD_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [1:0]                       i_command,
    input  wire  [KEY_BITS-1:0]              i_key_in,
    input  wire  [CHILD_BITS-1:0]            i_child_in,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [KEY_BITS-1:0]              o_key_out,
    output logic [CHILD_BITS-1:0]            o_child_out,
    output logic [$clog2(KEY_SLOTS+1)-1:0]   o_key_count,
    output logic                             o_last
);

    localparam int CW  = $clog2(KEY_SLOTS + 1);
    localparam int LW  = $clog2(KEY_SLOTS + 2);
    localparam int NC  = KEY_SLOTS + 1;

    btnode_pkg::t_state     r_state, n_state;
    btnode_pkg::t_cmd       r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [CHILD_BITS-1:0]  r_child;
    logic [CHILD_BITS-1:0]  r_child0, n_child0;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_mid, n_mid;
    logic [LW-1:0]          r_left, n_left;
    logic [NC-1:0]          r_gt;

    logic                   r_valid, n_valid;
    btnode_pkg::t_status    r_status, n_status;
    logic [KEY_BITS-1:0]    r_key_out, n_key_out;
    logic [CHILD_BITS-1:0]  r_child_out, n_child_out;
    logic                   r_last, n_last;

    logic [KEY_BITS-1:0]    w_key   [0:NC-1];
    logic [CHILD_BITS-1:0]  w_child [0:NC-1];
    logic [NC-1:0]          w_gt;
    logic [NC-1:0]          w_gt_eff;
    btnode_pkg::t_cell_ctrl w_ctrl  [0:NC-1];

    logic                   w_accept;
    logic [LW-1:0]          w_total;
    logic [CW-1:0]          w_half;

    assign w_accept = start && !busy;
    assign w_total  = LW'(r_count) + LW'(1);
    assign w_half   = CW'(w_total >> 1);

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_cell
            logic [KEY_BITS-1:0]   w_lk;
            logic [CHILD_BITS-1:0] w_lc;
            logic [KEY_BITS-1:0]   w_rk;
            logic [CHILD_BITS-1:0] w_rc;
            if (gi == 0) begin : g_first
                assign w_lk = '0;
                assign w_lc = '0;
            end else begin : g_mid
                assign w_lk = w_key[gi-1];
                assign w_lc = w_child[gi-1];
            end
            if (gi == NC - 1) begin : g_end
                assign w_rk = '0;
                assign w_rc = '0;
            end else begin : g_inner
                assign w_rk = w_key[gi+1];
                assign w_rc = w_child[gi+1];
            end
            btnode_cell #(
                .KEY_BITS   (KEY_BITS),
                .CHILD_BITS (CHILD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl[gi]),
                .i_cmp_key     (r_key),
                .i_new_key     (r_key),
                .i_new_child   (r_child),
                .i_left_key    (w_lk),
                .i_left_child  (w_lc),
                .i_right_key   (w_rk),
                .i_right_child (w_rc),
                .o_key         (w_key[gi]),
                .o_child       (w_child[gi]),
                .o_gt          (w_gt[gi])
            );
            assign w_gt_eff[gi] = w_gt[gi] || (CW'(gi) >= r_count);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btnode_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= btnode_pkg::t_cmd'(i_command);
            r_key   <= i_key_in;
            r_child <= i_child_in;
        end
        if (r_state == btnode_pkg::S_CMP) begin
            r_gt <= w_gt_eff;
        end
        r_child0    <= n_child0;
        r_mid       <= n_mid;
        r_left      <= n_left;
        r_status    <= n_status;
        r_key_out   <= n_key_out;
        r_child_out <= n_child_out;
        r_last      <= n_last;
    end

    always_comb begin
        logic ins;
        logic prev;
        ins         = 1'b0;
        prev        = 1'b0;
        n_state     = r_state;
        n_count     = r_count;
        n_child0    = r_child0;
        n_mid       = r_mid;
        n_left      = r_left;
        n_valid     = 1'b0;
        n_status    = btnode_pkg::ST_OK;
        n_key_out   = '0;
        n_child_out = '0;
        n_last      = 1'b0;
        for (int i = 0; i < NC; i++) begin
            w_ctrl[i] = '0;
        end
        case (r_state)
            btnode_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = btnode_pkg::S_CMP;
                end
            end
            btnode_pkg::S_CMP: begin
                n_state = btnode_pkg::S_EXEC;
            end
            btnode_pkg::S_EXEC: begin
                n_state = btnode_pkg::S_IDLE;
                n_valid = 1'b1;
                n_last  = 1'b1;
                case (r_cmd)
                    btnode_pkg::CMD_INIT: begin
                        n_count  = '0;
                        n_child0 = r_child;
                    end
                    btnode_pkg::CMD_LOOKUP: begin
                        for (int i = 0; i < NC; i++) begin
                            if (r_gt[i] && !prev) begin
                                n_child_out = n_child_out |
                                    ((i == 0) ? r_child0 : w_child[(i == 0) ? 0 : i-1]);
                            end
                            prev = r_gt[i];
                        end
                    end
                    btnode_pkg::CMD_INSERT: begin
                        if (r_count == CW'(KEY_SLOTS)) begin
                            n_status = btnode_pkg::ST_FULL;
                        end else begin
                            ins     = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    btnode_pkg::CMD_SPLIT: begin
                        ins     = 1'b1;
                        n_count = w_half;
                        n_mid   = w_half;
                        n_left  = w_total - LW'(w_half);
                        n_valid = 1'b0;
                        n_last  = 1'b0;
                        n_state = btnode_pkg::S_EMIT;
                    end
                    default: begin
                        n_state = btnode_pkg::S_IDLE;
                    end
                endcase
                prev = 1'b0;
                for (int i = 0; i < NC; i++) begin
                    w_ctrl[i].load      = ins && r_gt[i] && !prev;
                    w_ctrl[i].from_left = ins && r_gt[i] && prev;
                    prev = r_gt[i];
                end
            end
            btnode_pkg::S_EMIT: begin
                n_valid  = 1'b1;
                n_status = btnode_pkg::ST_SPLIT;
                n_left   = r_left - LW'(1);
                n_last   = (r_left == LW'(1));
                for (int i = 0; i < NC; i++) begin
                    if (CW'(i) == r_mid) begin
                        n_key_out   = n_key_out | w_key[i];
                        n_child_out = n_child_out | w_child[i];
                    end
                    w_ctrl[i].from_right = (CW'(i) >= r_mid);
                end
                if (r_left == LW'(1)) begin
                    n_state = btnode_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = btnode_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != btnode_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_key_out   = r_key_out;
    assign o_child_out = r_child_out;
    assign o_key_count = r_count;
    assign o_last      = r_last;

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status == btnode_pkg::ST_FULL) |-> r_count == CW'(KEY_SLOTS))
        else $error("full reported below capacity");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(KEY_SLOTS))
        else $error("key count beyond slots");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_last |=> !r_valid)
        else $error("result right after last transfer");

    a_valid_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> r_state == btnode_pkg::S_EMIT)
        else $error("split result outside emit");

endmodule

`default_nettype wire
